// ===== hdl/permutation_unrank_unit_macros.svh =====
// assertion macros shared by the permutation unrank checker
`ifndef PERMUTATION_UNRANK_UNIT_MACROS_SVH
`define PERMUTATION_UNRANK_UNIT_MACROS_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define PUU_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("permutation unrank check failed");

// clocked assertion on the block clock and reset
`define PUU_ASSERT(label, prop) \
    `PUU_ASSERT_CLK(label, aclk, aresetn, prop)

`endif

// ===== hdl/puu_pkg.sv =====
// shared constants, types and tables for the permutation unrank unit
package puu_pkg;

    localparam int MAX_N      = 12;
    localparam int RANK_W     = 29;
    localparam int ELEM_W     = 4;
    localparam int IDX_W      = 4;
    localparam int LEN_W      = 4;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index as seen in paddr[2]
    localparam logic REG_PERM_LENGTH = 1'b0;

    localparam logic [LEN_W-1:0] PERM_LENGTH_RESET = LEN_W'(12);

    typedef struct packed {
        logic load;     // start a new rank, fill the pool with 1..n
        logic advance;  // one digit taken, remove the picked value
    } cell_ctrl_t;

    // factorial of a small value, 1 for codes above the range
    function automatic logic [RANK_W-1:0] fact_of(input logic [IDX_W-1:0] m);
        logic [RANK_W-1:0] f;
        case (m)
            4'd0:    f = RANK_W'(1);
            4'd1:    f = RANK_W'(1);
            4'd2:    f = RANK_W'(2);
            4'd3:    f = RANK_W'(6);
            4'd4:    f = RANK_W'(24);
            4'd5:    f = RANK_W'(120);
            4'd6:    f = RANK_W'(720);
            4'd7:    f = RANK_W'(5040);
            4'd8:    f = RANK_W'(40320);
            4'd9:    f = RANK_W'(362880);
            4'd10:   f = RANK_W'(3628800);
            4'd11:   f = RANK_W'(39916800);
            4'd12:   f = RANK_W'(479001600);
            default: f = RANK_W'(1);
        endcase
        return f;
    endfunction

endpackage

// ===== hdl/puu_cell.sv =====
// one pool cell: holds an unused value and its digit threshold
module puu_cell (
    input  logic                          aclk,
    input  logic [puu_pkg::IDX_W-1:0]     cell_idx,
    input  puu_pkg::cell_ctrl_t           ctrl,
    input  logic [puu_pkg::RANK_W-1:0]    fact_in,
    input  logic [puu_pkg::RANK_W-1:0]    rem_in,
    input  logic                          ge_next_in,
    input  logic [puu_pkg::ELEM_W-1:0]    val_next_in,
    output logic                          ge_out,
    output logic [puu_pkg::ELEM_W-1:0]    val_out,
    output logic [puu_pkg::ELEM_W-1:0]    sel_val_out,
    output logic [puu_pkg::RANK_W-1:0]    sel_mult_out
);
    import puu_pkg::*;

    logic [ELEM_W-1:0]       val_reg, val_next;
    logic [RANK_W-1:0]       mult_reg, mult_next;
    logic [RANK_W+IDX_W-1:0] prod;
    logic                    picked;

    // threshold for this position is cell_idx times the current factorial
    assign prod      = fact_in * cell_idx;
    assign mult_next = prod[RANK_W-1:0];

    assign ge_out  = (rem_in >= mult_reg);
    assign picked  = ge_out && !ge_next_in;
    assign val_out = val_reg;

    assign sel_val_out  = picked ? val_reg  : '0;
    assign sel_mult_out = picked ? mult_reg : '0;

    always_comb begin
        val_next = val_reg;
        if (ctrl.load) begin
            val_next = ELEM_W'(cell_idx) + ELEM_W'(1);
        end else if (ctrl.advance && !ge_next_in) begin
            // at or above the picked slot: close the gap
            val_next = val_next_in;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        if (ctrl.load || ctrl.advance) begin
            mult_reg <= mult_next;
        end
    end

endmodule

// ===== hdl/permutation_unrank_unit.sv =====
// top level of the permutation unrank unit: control, config port and cell row
// a rank transaction loads the cells; each digit step after it registers one result
// throughput: one result per cycle while the output register is free, after the setup step;
//   a rejected rank gives a single error result; the digit step through the cell row sets this
// output register lets the next rank enter while the final result still waits
// reset: aresetn synchronous active low, clears control and sets perm_length to 12
module permutation_unrank_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // rank input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [puu_pkg::S_TDATA_W-1:0]       s_tdata,   // [28:0] rank, zero fill above
    // permutation output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [puu_pkg::M_TDATA_W-1:0]       m_tdata,   // [3:0] element, zero fill above
    output logic                                m_tlast,   // last_element
    output logic                                m_tuser,   // [0] rank_error
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [puu_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [puu_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [puu_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import puu_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                 state_reg, state_next;
    logic [RANK_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]     digit_reg, digit_next;   // digits left after this one
    logic                 err_reg, err_next;
    logic [LEN_W-1:0]     perm_length_reg, perm_length_next;

    logic                 out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0]    out_elem_reg, out_elem_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_err_reg, out_err_next;

    logic                 in_accept;
    logic                 out_free;
    logic                 step;
    logic [IDX_W-1:0]     n_eff;
    logic [RANK_W-1:0]    rank_in;
    logic [RANK_W-1:0]    fact_to_cells;
    logic [ELEM_W-1:0]    pick_val;
    logic [RANK_W-1:0]    pick_mult;
    logic                 cfg_write;
    cell_ctrl_t           cell_ctrl;

    // neighbor links along the row, one extra slot past the end
    logic                 ge_w [MAX_N+1];
    logic [ELEM_W-1:0]    val_w [MAX_N+1];
    logic [ELEM_W-1:0]    sel_val_w [MAX_N];
    logic [RANK_W-1:0]    sel_mult_w [MAX_N];

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_PERM_LENGTH)
                     ? {{(APB_DATA_W-LEN_W){1'b0}}, perm_length_reg} : '0;

    always_comb begin
        perm_length_next = perm_length_reg;
        if (cfg_write && (paddr[2] == REG_PERM_LENGTH)) begin
            perm_length_next = pwdata[LEN_W-1:0];
        end
    end

    // length zero acts as one, above the maximum saturates
    always_comb begin
        if (perm_length_reg == '0) begin
            n_eff = IDX_W'(1);
        end else if (perm_length_reg > LEN_W'(MAX_N)) begin
            n_eff = IDX_W'(MAX_N);
        end else begin
            n_eff = perm_length_reg;
        end
    end

    // ---------------- handshakes ----------------
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign step      = (state_reg == ST_RUN) && out_free;
    assign rank_in   = s_tdata[RANK_W-1:0];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-ELEM_W){1'b0}}, out_elem_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    // ---------------- cell row ----------------
    assign cell_ctrl.load    = in_accept;
    assign cell_ctrl.advance = step && !err_reg;

    // cells hold thresholds for the digit about to be taken
    assign fact_to_cells = in_accept ? fact_of(n_eff - IDX_W'(1))
                                     : fact_of(digit_reg - IDX_W'(1));

    assign ge_w[MAX_N]  = 1'b0;
    assign val_w[MAX_N] = '0;

    for (genvar i = 0; i < MAX_N; i++) begin : g_cell
        puu_cell u_cell (
            .aclk        (aclk),
            .cell_idx    (IDX_W'(i)),
            .ctrl        (cell_ctrl),
            .fact_in     (fact_to_cells),
            .rem_in      (rem_reg),
            .ge_next_in  (ge_w[i+1]),
            .val_next_in (val_w[i+1]),
            .ge_out      (ge_w[i]),
            .val_out     (val_w[i]),
            .sel_val_out (sel_val_w[i]),
            .sel_mult_out(sel_mult_w[i])
        );
    end

    // exactly one cell is picked, so an or over the row is the mux
    always_comb begin
        pick_val  = '0;
        pick_mult = '0;
        for (int i = 0; i < MAX_N; i++) begin
            pick_val  = pick_val  | sel_val_w[i];
            pick_mult = pick_mult | sel_mult_w[i];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        digit_next     = digit_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (in_accept) begin
            // rank zero or above n factorial is rejected
            err_next   = (rank_in == '0) || (rank_in > fact_of(n_eff));
            rem_next   = rank_in - RANK_W'(1);
            digit_next = n_eff - IDX_W'(1);
            state_next = ST_RUN;
        end else if (step) begin
            out_valid_next = 1'b1;
            if (err_reg) begin
                out_elem_next = '0;
                out_last_next = 1'b1;
                out_err_next  = 1'b1;
                state_next    = ST_IDLE;
            end else begin
                out_elem_next = pick_val;
                out_last_next = (digit_reg == '0);
                out_err_next  = 1'b0;
                rem_next      = rem_reg - pick_mult;
                digit_next    = digit_reg - IDX_W'(1);
                if (digit_reg == '0) begin
                    state_next = ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            perm_length_reg <= PERM_LENGTH_RESET;
        end else begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            perm_length_reg <= perm_length_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        digit_reg    <= digit_next;
        err_reg      <= err_next;
        out_elem_reg <= out_elem_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

endmodule

// ===== hdl/puu_checker.sv =====
// port-level checks for the permutation unrank unit, bound to the top level
`include "permutation_unrank_unit_macros.svh"

module puu_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [puu_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser
);
    import puu_pkg::*;

    // a stalled result holds its payload
    `PUU_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))

    // a rejected rank gives one marked result with a zero element
    `PUU_ASSERT(a_err_shape, (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))

    // a good result carries a value in 1..MAX_N
    `PUU_ASSERT(a_elem_range, (m_tvalid && !m_tuser) |-> ((m_tdata != '0) && (m_tdata <= M_TDATA_W'(MAX_N))))

    // one rank at a time: input closes right after a transaction
    `PUU_ASSERT(a_one_rank, (s_tvalid && s_tready) |=> !s_tready)

endmodule

bind permutation_unrank_unit puu_checker u_puu_checker (.*);

// ===== sim/tb_permutation_unrank_unit.sv =====
// self-checking testbench for the permutation unrank unit: directed table, then random ranks
module tb_permutation_unrank_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import puu_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 23;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 32;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 47;
    localparam int QUIET_PHASE  = 3;
    localparam int DIR_ROWS     = 26;

    localparam logic [RANK_W-1:0]     RANK_ALL_ONES    = '1;
    localparam logic [APB_ADDR_W-1:0] PERM_LENGTH_ADDR = {REG_PERM_LENGTH, 2'b00};

    // one element transaction on the result side
    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last_element;
        logic              rank_error;
    } perm_elem_t;

    // how the expected elements of a directed row are obtained
    typedef enum logic [1:0] {
        OUT_PREDICTED,   // worked out by the unranking predictor
        OUT_ASCENDING,   // first permutation: 1..n
        OUT_DESCENDING,  // last permutation: n..1
        OUT_REJECTED     // single error element
    } known_out_t;

    typedef enum logic {
        ROW_SET_LENGTH,
        ROW_RANK
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [RANK_W-1:0] value;
        known_out_t        known;
    } dir_row_t;

    // directed stimulus, starting from the reset length of 12
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_RANK,       29'd1,           OUT_ASCENDING},
        '{ROW_RANK,       29'd479001600,   OUT_DESCENDING},
        '{ROW_RANK,       29'd0,           OUT_REJECTED},
        '{ROW_RANK,       29'd479001601,   OUT_REJECTED},
        '{ROW_RANK,       RANK_ALL_ONES,   OUT_REJECTED},
        '{ROW_RANK,       29'd2,           OUT_PREDICTED},
        '{ROW_RANK,       29'd239500800,   OUT_PREDICTED},
        // single value
        '{ROW_SET_LENGTH, 29'd1,           OUT_PREDICTED},
        '{ROW_RANK,       29'd1,           OUT_ASCENDING},
        '{ROW_RANK,       29'd2,           OUT_REJECTED},
        // zero length behaves as length one
        '{ROW_SET_LENGTH, 29'd0,           OUT_PREDICTED},
        '{ROW_RANK,       29'd1,           OUT_ASCENDING},
        '{ROW_RANK,       29'd2,           OUT_REJECTED},
        // length above the maximum saturates to 12
        '{ROW_SET_LENGTH, 29'd15,          OUT_PREDICTED},
        '{ROW_RANK,       29'd479001600,   OUT_DESCENDING},
        '{ROW_RANK,       29'd479001601,   OUT_REJECTED},
        // ranks of short permutations, both ends and one past the end included
        '{ROW_SET_LENGTH, 29'd3,           OUT_PREDICTED},
        '{ROW_RANK,       29'd1,           OUT_ASCENDING},
        '{ROW_RANK,       29'd3,           OUT_PREDICTED},
        '{ROW_RANK,       29'd4,           OUT_PREDICTED},
        '{ROW_RANK,       29'd6,           OUT_DESCENDING},
        '{ROW_RANK,       29'd7,           OUT_REJECTED},
        '{ROW_SET_LENGTH, 29'd5,           OUT_PREDICTED},
        '{ROW_RANK,       29'd120,         OUT_DESCENDING},
        '{ROW_RANK,       29'd57,          OUT_PREDICTED},
        '{ROW_RANK,       29'h1000_0000,   OUT_REJECTED}
    };

    // lengths of the random phases, extremes and out-of-range codes among them
    localparam logic [LEN_W-1:0] PHASE_LENGTH [RAND_PHASES] = '{
        4'd12, 4'd4, 4'd1, 4'd9, 4'd0, 4'd15, 4'd6, 4'd2, 4'd11, 4'd7
    };

    // dut inputs, all known from time zero
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state: the length register as the block should hold it
    logic [LEN_W-1:0] length_shadow = PERM_LENGTH_RESET;

    perm_elem_t pending_elems [$];

    bit no_idle          = 1'b0;
    int errors           = 0;
    int cycle_count      = 0;
    int ranks_sent       = 0;
    int ranks_rejected   = 0;
    int elements_checked = 0;
    int length_writes    = 0;

    permutation_unrank_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d elements still awaited",
                     $time, cycle_count, pending_elems.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side back-pressure, off during the quiet stretch
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare every element transaction with the oldest expectation
    always @(posedge aclk) begin
        perm_elem_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_elems.size() == 0) begin
                $display("%0t: unexpected element transaction: element %0d last %0b error %0b",
                         $time, m_tdata[ELEM_W-1:0], m_tlast, m_tuser);
                errors++;
            end else begin
                want = pending_elems.pop_front();
                elements_checked++;
                if (m_tdata[ELEM_W-1:0] !== want.element) begin
                    $display("%0t: element mismatch: expected %0d, got %0d",
                             $time, want.element, m_tdata[ELEM_W-1:0]);
                    errors++;
                end
                if (m_tlast !== want.last_element) begin
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, want.last_element, m_tlast);
                    errors++;
                end
                if (m_tuser !== want.rank_error) begin
                    $display("%0t: rank error mismatch: expected %0b, got %0b",
                             $time, want.rank_error, m_tuser);
                    errors++;
                end
            end
        end
    end

    function automatic longint unsigned factorial(input int m);
        longint unsigned f = 1;
        for (int i = 2; i <= m; i++)
            f *= i;
        return f;
    endfunction

    // append one awaited element transaction
    function automatic void expect_elem(input logic [ELEM_W-1:0] el, input logic is_last,
                                        input logic is_err);
        perm_elem_t e;
        e.element      = el;
        e.last_element = is_last;
        e.rank_error   = is_err;
        pending_elems  = {pending_elems, e};
    endfunction

    // zero counts as one, codes above the maximum saturate
    function automatic int active_length();
        if (length_shadow == 0)
            return 1;
        if (length_shadow > MAX_N)
            return MAX_N;
        return int'(length_shadow);
    endfunction

    // factorial number system: each digit picks from the values still unused
    function automatic void unrank_expected(input logic [RANK_W-1:0] rank);
        int                n;
        int                sel;
        int                left;
        longint unsigned   r;
        longint unsigned   f;
        logic [ELEM_W-1:0] pool [MAX_N];
        n = active_length();
        if (rank == 0 || rank > factorial(n)) begin
            expect_elem('0, 1'b1, 1'b1);
            ranks_rejected++;
            return;
        end
        r = rank - 1;
        for (int i = 0; i < n; i++)
            pool[i] = ELEM_W'(i + 1);
        left = n;
        for (int i = 0; i < n; i++) begin
            f   = factorial(n - 1 - i);
            sel = int'(r / f);
            if (sel >= left)
                sel = left - 1;
            expect_elem(pool[sel], (i == n - 1), 1'b0);
            for (int j = sel; j + 1 < left; j++)
                pool[j] = pool[j + 1];
            left--;
            r = r % f;
        end
    endfunction

    // expectations typed in by the table, or from the predictor
    function automatic void book_expected(input logic [RANK_W-1:0] rank, input known_out_t known);
        int n;
        n = active_length();
        case (known)
            OUT_ASCENDING: begin
                for (int i = 1; i <= n; i++)
                    expect_elem(ELEM_W'(i), (i == n), 1'b0);
            end
            OUT_DESCENDING: begin
                for (int i = n; i >= 1; i--)
                    expect_elem(ELEM_W'(i), (i == 1), 1'b0);
            end
            OUT_REJECTED: begin
                expect_elem('0, 1'b1, 1'b1);
                ranks_rejected++;
            end
            default: unrank_expected(rank);
        endcase
    endfunction

    // mostly legal ranks, plus boundaries, zero and anything the 29 bits allow
    function automatic logic [RANK_W-1:0] pick_rank();
        longint unsigned nf;
        nf = factorial(active_length());
        case ($urandom_range(19))
            0:       return '0;
            1:       return RANK_W'(nf);
            2:       return RANK_W'(nf + 1);
            3:       return RANK_W'(1);
            4, 5:    return RANK_W'($urandom);
            6:       return RANK_W'($urandom_range(RANK_ALL_ONES, nf + 1));
            default: return RANK_W'($urandom_range(nf, 1));
        endcase
    endfunction

    // one rank transaction, with random idle cycles ahead of it
    task automatic send_rank(input logic [RANK_W-1:0] rank, input known_out_t known);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(rank);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        book_expected(rank, known);
        ranks_sent++;
    endtask

    // stop sending and let every awaited element come out
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (pending_elems.size() != 0)
            @(posedge aclk);
    endtask

    // length write through the config port, then a read back
    task automatic set_perm_length(input logic [LEN_W-1:0] len);
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        // write: setup then access
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PERM_LENGTH_ADDR;
        pwdata  <= APB_DATA_W'(len);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (prdata !== APB_DATA_W'(len)) begin
            $display("%0t: perm_length read back mismatch: expected %0d, got %0d",
                     $time, len, prdata);
            errors++;
        end
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        length_shadow = len;
        length_writes++;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (DIR_TABLE[i]) begin
            if (DIR_TABLE[i].kind == ROW_SET_LENGTH) begin
                set_perm_length(LEN_W'(DIR_TABLE[i].value));
            end else begin
                send_rank(DIR_TABLE[i].value, DIR_TABLE[i].known);
            end
        end

        // random phases, one length each; one phase runs with no idling at all
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_perm_length(PHASE_LENGTH[p]);
            no_idle = (p == QUIET_PHASE);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // mid-phase pause until the block has emptied
                if (p == 0 && k == PHASE_ITEMS / 2)
                    hold_until_drained();
                send_rank(pick_rank(), OUT_PREDICTED);
            end
            no_idle = 1'b0;
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("ran %0d ranks (%0d rejected) under %0d length writes",
                 ranks_sent, ranks_rejected, length_writes);
        $display("checked %0d element transactions in %0d cycles",
                 elements_checked, cycle_count);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/puu_pkg.sv
hdl/puu_cell.sv
hdl/permutation_unrank_unit.sv
hdl/puu_checker.sv
sim/tb_permutation_unrank_unit.sv
